[rtl/core/s5hp_pkg.sv]
// Shared types and protocol constants for the SOCKS5 handshake parser.
`timescale 1ns / 1ps

package s5hp_pkg;

  // Protocol byte values
  localparam logic [7:0] SOCKS_VER    = 8'h05;
  localparam logic [7:0] METH_NO_AUTH = 8'h00;
  localparam logic [7:0] CMD_FIRST    = 8'h01;
  localparam logic [7:0] CMD_LAST     = 8'h03;
  localparam logic [7:0] RSV_BYTE     = 8'h00;
  localparam logic [7:0] ATYP_IPV4    = 8'h01;
  localparam logic [7:0] ATYP_NAME    = 8'h03;
  localparam logic [7:0] ATYP_IPV6    = 8'h04;
  localparam logic [7:0] IPV4_BYTES   = 8'd4;
  localparam logic [7:0] IPV6_BYTES   = 8'd16;

  typedef enum logic [2:0] {
    EV_NAME   = 3'd0,
    EV_G_OK   = 3'd1,
    EV_G_BAD  = 3'd2,
    EV_R_OK   = 3'd3,
    EV_R_BAD  = 3'd4,
    EV_CLOSED = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    RSN_GENERAL = 2'd0,
    RSN_CMD     = 2'd1,
    RSN_ATYP    = 2'd2
  } reason_e;

  typedef enum logic [1:0] {
    KIND_IPV4 = 2'd0,
    KIND_NAME = 2'd1,
    KIND_IPV6 = 2'd2
  } kind_e;

  typedef struct packed {
    event_e      event_res;
    reason_e     reason;
    logic [1:0]  command;
    kind_e       addr_kind;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] dest_port;
    logic [7:0]  host_length;
    logic [7:0]  host_byte;
  } res_t;

endpackage

[rtl/core/s5hp_if.sv]
// Channel interfaces: client byte input, parse result output, config write.
`timescale 1ns / 1ps

interface s5hp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       conn_start;

  modport source (output valid, output data_byte, output conn_start, input ready);
  modport sink (input valid, input data_byte, input conn_start, output ready);
endinterface

interface s5hp_out_if;
  logic                 valid;
  logic                 ready;
  s5hp_pkg::event_e     event_res;
  s5hp_pkg::reason_e    reason;
  logic [1:0]           command;
  s5hp_pkg::kind_e      addr_kind;
  logic [63:0]          addr_high;
  logic [63:0]          addr_low;
  logic [15:0]          dest_port;
  logic [7:0]           host_length;
  logic [7:0]           host_byte;

  modport source (output valid, output event_res, output reason, output command,
                  output addr_kind, output addr_high, output addr_low, output dest_port,
                  output host_length, output host_byte, input ready);
  modport sink (input valid, input event_res, input reason, input command,
                input addr_kind, input addr_high, input addr_low, input dest_port,
                input host_length, input host_byte, output ready);
endinterface

interface s5hp_cfg_if;
  logic valid;
  logic ready;
  logic disable_ipv6;

  modport source (output valid, output disable_ipv6, input ready);
  modport sink (input valid, input disable_ipv6, output ready);
endinterface

[rtl/core/s5hp_parse.sv]
// Handshake state machine: one client byte per step, at most one result.
`timescale 1ns / 1ps

module s5hp_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     data_byte_i,
  input  logic           conn_start_i,
  input  logic           disable_ipv6_i,
  output logic           res_vld_o,
  output s5hp_pkg::res_t res_o
);
  import s5hp_pkg::*;

  typedef enum logic [3:0] {
    PH_G_VER   = 4'd0,
    PH_G_NMETH = 4'd1,
    PH_G_METH  = 4'd2,
    PH_R_VER   = 4'd3,
    PH_R_CMD   = 4'd4,
    PH_R_RSV   = 4'd5,
    PH_R_ATYP  = 4'd6,
    PH_A4      = 4'd7,
    PH_A6      = 4'd8,
    PH_NLEN    = 4'd9,
    PH_NAME    = 4'd10,
    PH_P_HI    = 4'd11,
    PH_P_LO    = 4'd12,
    PH_DONE    = 4'd13,
    PH_CLOSED  = 4'd14
  } phase_e;

  phase_e      phase_q, phase_d, cur_phase;
  logic [7:0]  cnt_q, cnt_d, cur_cnt, cnt_inc;
  logic [7:0]  meth_q, meth_d, cur_meth;
  logic        no_auth_q, no_auth_d, cur_no_auth;
  logic [1:0]  cmd_q, cmd_d, cur_cmd;
  kind_e       atype_q, atype_d, cur_atype;
  logic [63:0] hi_q, hi_d, cur_hi;
  logic [63:0] lo_q, lo_d, cur_lo;
  logic [15:0] port_q, port_d, cur_port;
  logic [7:0]  nlen_q, nlen_d, cur_nlen;
  logic [7:0]  b;

  assign b = data_byte_i;

  always_comb begin
    // a new connection sees cleared state before its first byte
    if (conn_start_i) begin
      cur_phase   = PH_G_VER;
      cur_cnt     = '0;
      cur_meth    = '0;
      cur_no_auth = 1'b0;
      cur_cmd     = '0;
      cur_atype   = KIND_IPV4;
      cur_hi      = '0;
      cur_lo      = '0;
      cur_port    = '0;
      cur_nlen    = '0;
    end else begin
      cur_phase   = phase_q;
      cur_cnt     = cnt_q;
      cur_meth    = meth_q;
      cur_no_auth = no_auth_q;
      cur_cmd     = cmd_q;
      cur_atype   = atype_q;
      cur_hi      = hi_q;
      cur_lo      = lo_q;
      cur_port    = port_q;
      cur_nlen    = nlen_q;
    end
  end

  assign cnt_inc = cur_cnt + 8'd1;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    meth_d    = meth_q;
    no_auth_d = no_auth_q;
    cmd_d     = cmd_q;
    atype_d   = atype_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    port_d    = port_q;
    nlen_d    = nlen_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    if (step_i) begin
      phase_d   = cur_phase;
      cnt_d     = cur_cnt;
      meth_d    = cur_meth;
      no_auth_d = cur_no_auth;
      cmd_d     = cur_cmd;
      atype_d   = cur_atype;
      hi_d      = cur_hi;
      lo_d      = cur_lo;
      port_d    = cur_port;
      nlen_d    = cur_nlen;
      unique case (cur_phase)
        PH_G_VER: begin
          if (b != SOCKS_VER) begin
            phase_d         = PH_CLOSED;
            res_vld_o       = 1'b1;
            res_o.event_res = EV_G_BAD;
          end else begin
            phase_d = PH_G_NMETH;
          end
        end
        PH_G_NMETH: begin
          meth_d = b;
          cnt_d  = '0;
          if (b == 8'd0) begin
            phase_d         = PH_CLOSED;
            res_vld_o       = 1'b1;
            res_o.event_res = EV_G_BAD;
          end else begin
            phase_d = PH_G_METH;
          end
        end
        PH_G_METH: begin
          no_auth_d = cur_no_auth | (b == METH_NO_AUTH);
          cnt_d     = cnt_inc;
          if (cnt_inc == cur_meth) begin
            res_vld_o = 1'b1;
            if (!no_auth_d) begin
              phase_d         = PH_CLOSED;
              res_o.event_res = EV_G_BAD;
            end else begin
              phase_d         = PH_R_VER;
              res_o.event_res = EV_G_OK;
            end
          end
        end
        PH_R_VER: begin
          if (b != SOCKS_VER) begin
            phase_d         = PH_CLOSED;
            res_vld_o       = 1'b1;
            res_o.event_res = EV_R_BAD;
            res_o.reason    = RSN_GENERAL;
          end else begin
            phase_d = PH_R_CMD;
          end
        end
        PH_R_CMD: begin
          if (b < CMD_FIRST || b > CMD_LAST) begin
            phase_d         = PH_CLOSED;
            res_vld_o       = 1'b1;
            res_o.event_res = EV_R_BAD;
            res_o.reason    = RSN_CMD;
          end else begin
            cmd_d   = b[1:0] - 2'd1;
            phase_d = PH_R_RSV;
          end
        end
        PH_R_RSV: begin
          if (b != RSV_BYTE) begin
            phase_d         = PH_CLOSED;
            res_vld_o       = 1'b1;
            res_o.event_res = EV_R_BAD;
            res_o.reason    = RSN_GENERAL;
          end else begin
            phase_d = PH_R_ATYP;
          end
        end
        PH_R_ATYP: begin
          hi_d   = '0;
          lo_d   = '0;
          nlen_d = '0;
          cnt_d  = '0;
          if (b == ATYP_IPV4) begin
            atype_d = KIND_IPV4;
            phase_d = PH_A4;
          end else if (b == ATYP_NAME) begin
            atype_d = KIND_NAME;
            phase_d = PH_NLEN;
          end else if (b == ATYP_IPV6) begin
            atype_d = KIND_IPV6;
            phase_d = PH_A6;
          end else begin
            phase_d         = PH_CLOSED;
            res_vld_o       = 1'b1;
            res_o.event_res = EV_R_BAD;
            res_o.reason    = RSN_ATYP;
          end
        end
        PH_A4: begin
          lo_d  = {32'd0, cur_lo[23:0], b};
          cnt_d = cnt_inc;
          if (cnt_inc >= IPV4_BYTES) begin
            phase_d = PH_P_HI;
          end
        end
        PH_A6: begin
          // shift the 128-bit address left by one byte
          hi_d  = {cur_hi[55:0], cur_lo[63:56]};
          lo_d  = {cur_lo[55:0], b};
          cnt_d = cnt_inc;
          if (cnt_inc >= IPV6_BYTES) begin
            if (disable_ipv6_i) begin
              phase_d         = PH_CLOSED;
              res_vld_o       = 1'b1;
              res_o.event_res = EV_R_BAD;
              res_o.reason    = RSN_ATYP;
            end else begin
              phase_d = PH_P_HI;
            end
          end
        end
        PH_NLEN: begin
          nlen_d  = b;
          cnt_d   = '0;
          phase_d = (b == 8'd0) ? PH_P_HI : PH_NAME;
        end
        PH_NAME: begin
          res_vld_o         = 1'b1;
          res_o.event_res   = EV_NAME;
          res_o.command     = cur_cmd;
          res_o.addr_kind   = cur_atype;
          res_o.host_length = cur_nlen;
          res_o.host_byte   = b;
          cnt_d             = cnt_inc;
          if (cnt_inc >= cur_nlen) begin
            phase_d = PH_P_HI;
          end
        end
        PH_P_HI: begin
          port_d  = {b, 8'd0};
          phase_d = PH_P_LO;
        end
        PH_P_LO: begin
          port_d            = {cur_port[15:8], b};
          phase_d           = PH_DONE;
          res_vld_o         = 1'b1;
          res_o.event_res   = EV_R_OK;
          res_o.command     = cur_cmd;
          res_o.addr_kind   = cur_atype;
          res_o.addr_high   = cur_hi;
          res_o.addr_low    = cur_lo;
          res_o.dest_port   = {cur_port[15:8], b};
          res_o.host_length = (cur_atype == KIND_NAME) ? cur_nlen : 8'd0;
        end
        PH_DONE: begin
          phase_d         = PH_CLOSED;
          res_vld_o       = 1'b1;
          res_o.event_res = EV_CLOSED;
        end
        default: begin
          phase_d = PH_CLOSED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_G_VER;
      cnt_q     <= '0;
      meth_q    <= '0;
      no_auth_q <= 1'b0;
      cmd_q     <= '0;
      atype_q   <= KIND_IPV4;
      hi_q      <= '0;
      lo_q      <= '0;
      port_q    <= '0;
      nlen_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      meth_q    <= meth_d;
      no_auth_q <= no_auth_d;
      cmd_q     <= cmd_d;
      atype_q   <= atype_d;
      hi_q      <= hi_d;
      lo_q      <= lo_d;
      port_q    <= port_d;
      nlen_q    <= nlen_d;
    end
  end

  a_reject_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_vld_o && res_o.event_res == EV_R_BAD |=> phase_q == PH_CLOSED)
    else $error("reject did not close the connection");

  a_closed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !conn_start_i && phase_q == PH_CLOSED |-> !res_vld_o)
    else $error("result produced on a closed connection");

endmodule

[rtl/core/s5hp_out_buf.sv]
// Two-entry result queue that decouples the parser from the result receiver.
`timescale 1ns / 1ps

module s5hp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  s5hp_pkg::res_t    push_data_i,
  output logic              full_o,
  s5hp_out_if.source        res_o
);
  import s5hp_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;
  res_t       head;

  assign full_o = (cnt_q == 2'd2);
  assign pop    = res_o.valid && res_o.ready;
  assign head   = mem_q[rd_ptr_q];

  assign res_o.valid       = (cnt_q != 2'd0);
  assign res_o.event_res   = head.event_res;
  assign res_o.reason      = head.reason;
  assign res_o.command     = head.command;
  assign res_o.addr_kind   = head.addr_kind;
  assign res_o.addr_high   = head.addr_high;
  assign res_o.addr_low    = head.addr_low;
  assign res_o.dest_port   = head.dest_port;
  assign res_o.host_length = head.host_length;
  assign res_o.host_byte   = head.host_byte;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full result queue");

endmodule

[rtl/core/socks5_handshake_parser.sv]
// Top level of the SOCKS5 client handshake parser.
//
// Channels: in_i carries one client byte per word (data_byte) plus conn_start,
// which clears the parser before that byte is used. res_o carries at most one
// result word per input word: name byte, greeting accepted/rejected, request
// parsed/rejected (with reason) or closed. cfg_i writes disable_ipv6, taken
// at any cycle; write it only while the block is idle.
// Throughput: one byte per cycle while the result queue is not full. Each byte
// runs through one state-machine step between the input register and the
// two-entry result queue. A byte taken into the input register is parsed when
// the queue has room; its result is pushed into the queue in that step.
// Reset: asynchronous, active low; the parser waits for a greeting version
// byte, the queue is empty, disable_ipv6 is 0.
// Stall: when the receiver holds res_o.ready low the queue fills; with two
// results queued the input register stops advancing and in_i.ready drops
// once it holds a byte. No result is dropped or repeated.
`timescale 1ns / 1ps

module socks5_handshake_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  s5hp_in_if.sink     in_i,
  s5hp_out_if.source  res_o,
  s5hp_cfg_if.sink    cfg_i
);
  import s5hp_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       dis_v6_q;
  logic       step;
  logic       q_full;
  logic       res_vld;
  res_t       res;

  // advance the input word whenever the queue has room for its result
  assign step       = in_vld_q && !q_full;
  assign in_i.ready = !in_vld_q || step;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q  <= in_i.data_byte;
      in_start_q <= in_i.conn_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      dis_v6_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        dis_v6_q <= cfg_i.disable_ipv6;
      end
    end
  end

  s5hp_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .data_byte_i    (in_byte_q),
    .conn_start_i   (in_start_q),
    .disable_ipv6_i (dis_v6_q),
    .res_vld_o      (res_vld),
    .res_o          (res)
  );

  s5hp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res),
    .full_o      (q_full),
    .res_o       (res_o)
  );

endmodule

[tb/tb_socks5_handshake_parser.sv]
// Self-checking testbench for the SOCKS5 handshake parser: random sessions against a predictor.
`timescale 1ns / 1ps

module tb_socks5_handshake_parser;
  import s5hp_pkg::*;

  typedef enum logic [3:0] {
    PS_GREET_VER,
    PS_GREET_NMETH,
    PS_GREET_METH,
    PS_REQ_VER,
    PS_REQ_CMD,
    PS_REQ_RSV,
    PS_REQ_ATYP,
    PS_ADDR4,
    PS_ADDR6,
    PS_NAME_LEN,
    PS_NAME,
    PS_PORT_HI,
    PS_PORT_LO,
    PS_DONE,
    PS_CLOSED
  } parse_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       conn_start;
  } client_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  s5hp_in_if  in_if ();
  s5hp_out_if res_if ();
  s5hp_cfg_if cfg_if ();

  logic       in_valid_q   = 1'b0;
  logic [7:0] in_byte_q    = 8'h00;
  logic       in_start_q   = 1'b0;
  logic       res_ready_q  = 1'b0;
  logic       cfg_valid_q  = 1'b0;
  logic       cfg_ipv6_q   = 1'b0;

  assign in_if.valid         = in_valid_q;
  assign in_if.data_byte     = in_byte_q;
  assign in_if.conn_start    = in_start_q;
  assign res_if.ready        = res_ready_q;
  assign cfg_if.valid        = cfg_valid_q;
  assign cfg_if.disable_ipv6 = cfg_ipv6_q;

  socks5_handshake_parser dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  client_word_t client_words[$];
  res_t         parse_results_due[$];
  int unsigned  mismatches = 0;
  int unsigned  words_queued = 0;
  bit           steady = 1'b0;

  // Predictor state
  logic         ipv6_off = 1'b0;
  parse_state_e ps = PS_GREET_VER;
  logic [7:0]   cnt = '0;
  logic [7:0]   meth_total = '0;
  logic         noauth = 1'b0;
  logic [1:0]   cmd_q = '0;
  kind_e        kind_q = KIND_IPV4;
  logic [63:0]  hi_q = '0;
  logic [63:0]  lo_q = '0;
  logic [15:0]  port_q = '0;
  logic [7:0]   nlen_q = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_socks5_handshake_parser NOT OK");
    $finish;
  end

  function automatic res_t refusal(input reason_e why);
    res_t r;
    r = '0;
    r.event_res = EV_R_BAD;
    r.reason = why;
    return r;
  endfunction

  task automatic clear_parser();
    ps = PS_GREET_VER;
    cnt = '0;
    meth_total = '0;
    noauth = 1'b0;
    cmd_q = '0;
    kind_q = KIND_IPV4;
    hi_q = '0;
    lo_q = '0;
    port_q = '0;
    nlen_q = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic start, output bit got,
                            output res_t r);
    r = '0;
    got = 1'b0;
    if (start) clear_parser();
    case (ps)
      PS_GREET_VER: begin
        if (b != SOCKS_VER) begin
          ps = PS_CLOSED;
          r.event_res = EV_G_BAD;
          got = 1'b1;
        end else begin
          ps = PS_GREET_NMETH;
        end
      end
      PS_GREET_NMETH: begin
        meth_total = b;
        cnt = '0;
        if (b == 8'h00) begin
          ps = PS_CLOSED;
          r.event_res = EV_G_BAD;
          got = 1'b1;
        end else begin
          ps = PS_GREET_METH;
        end
      end
      PS_GREET_METH: begin
        if (b == METH_NO_AUTH) noauth = 1'b1;
        cnt = cnt + 8'd1;
        if (cnt == meth_total) begin
          got = 1'b1;
          if (!noauth) begin
            ps = PS_CLOSED;
            r.event_res = EV_G_BAD;
          end else begin
            ps = PS_REQ_VER;
            r.event_res = EV_G_OK;
          end
        end
      end
      PS_REQ_VER: begin
        if (b != SOCKS_VER) begin
          ps = PS_CLOSED;
          got = 1'b1;
          r = refusal(RSN_GENERAL);
        end else begin
          ps = PS_REQ_CMD;
        end
      end
      PS_REQ_CMD: begin
        if (b < CMD_FIRST || b > CMD_LAST) begin
          ps = PS_CLOSED;
          got = 1'b1;
          r = refusal(RSN_CMD);
        end else begin
          cmd_q = 2'(b - CMD_FIRST);
          ps = PS_REQ_RSV;
        end
      end
      PS_REQ_RSV: begin
        if (b != RSV_BYTE) begin
          ps = PS_CLOSED;
          got = 1'b1;
          r = refusal(RSN_GENERAL);
        end else begin
          ps = PS_REQ_ATYP;
        end
      end
      PS_REQ_ATYP: begin
        hi_q = '0;
        lo_q = '0;
        nlen_q = '0;
        cnt = '0;
        if (b == ATYP_IPV4) begin
          kind_q = KIND_IPV4;
          ps = PS_ADDR4;
        end else if (b == ATYP_NAME) begin
          kind_q = KIND_NAME;
          ps = PS_NAME_LEN;
        end else if (b == ATYP_IPV6) begin
          kind_q = KIND_IPV6;
          ps = PS_ADDR6;
        end else begin
          ps = PS_CLOSED;
          got = 1'b1;
          r = refusal(RSN_ATYP);
        end
      end
      PS_ADDR4: begin
        lo_q = {32'h0, lo_q[23:0], b};
        cnt = cnt + 8'd1;
        if (cnt >= IPV4_BYTES) ps = PS_PORT_HI;
      end
      PS_ADDR6: begin
        hi_q = {hi_q[55:0], lo_q[63:56]};
        lo_q = {lo_q[55:0], b};
        cnt = cnt + 8'd1;
        if (cnt >= IPV6_BYTES) begin
          if (ipv6_off) begin
            ps = PS_CLOSED;
            got = 1'b1;
            r = refusal(RSN_ATYP);
          end else begin
            ps = PS_PORT_HI;
          end
        end
      end
      PS_NAME_LEN: begin
        nlen_q = b;
        cnt = '0;
        ps = (b == 8'h00) ? PS_PORT_HI : PS_NAME;
      end
      PS_NAME: begin
        got = 1'b1;
        r.event_res = EV_NAME;
        r.command = cmd_q;
        r.addr_kind = kind_q;
        r.host_length = nlen_q;
        r.host_byte = b;
        cnt = cnt + 8'd1;
        if (cnt >= nlen_q) ps = PS_PORT_HI;
      end
      PS_PORT_HI: begin
        port_q = {b, 8'h00};
        ps = PS_PORT_LO;
      end
      PS_PORT_LO: begin
        port_q = {port_q[15:8], b};
        ps = PS_DONE;
        got = 1'b1;
        r.event_res = EV_R_OK;
        r.command = cmd_q;
        r.addr_kind = kind_q;
        r.addr_high = hi_q;
        r.addr_low = lo_q;
        r.dest_port = port_q;
        r.host_length = (kind_q == KIND_NAME) ? nlen_q : 8'h00;
      end
      PS_DONE: begin
        ps = PS_CLOSED;
        got = 1'b1;
        r.event_res = EV_CLOSED;
      end
      default: ps = PS_CLOSED;
    endcase
  endtask

  // Sender: hold a word until it is taken, then predict what it causes.
  always @(posedge clk) begin : drive_words
    bit           got;
    res_t         r;
    client_word_t word;
    if (rst_n) begin
      if (in_valid_q && in_if.ready) begin
        parse_byte(in_byte_q, in_start_q, got, r);
        if (got) parse_results_due.push_back(r);
      end
      if (!in_valid_q || in_if.ready) begin
        if (client_words.size() != 0 && (steady || $urandom_range(99, 0) >= 13)) begin
          word = client_words.pop_front();
          in_valid_q <= 1'b1;
          in_byte_q  <= word.data_byte;
          in_start_q <= word.conn_start;
        end else begin
          in_valid_q <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: check each taken result against the oldest prediction.
  always @(posedge clk) begin : watch_results
    res_t want;
    if (rst_n) begin
      if (res_if.valid && res_ready_q) begin
        if (parse_results_due.size() == 0) begin
          $error("result with no prediction: event_res %0d", res_if.event_res);
          mismatches++;
        end else begin
          want = parse_results_due.pop_front();
          cmp_field("event_res", want.event_res, res_if.event_res);
          cmp_field("reason", want.reason, res_if.reason);
          cmp_field("command", want.command, res_if.command);
          cmp_field("addr_kind", want.addr_kind, res_if.addr_kind);
          cmp_field("addr_high", want.addr_high, res_if.addr_high);
          cmp_field("addr_low", want.addr_low, res_if.addr_low);
          cmp_field("dest_port", want.dest_port, res_if.dest_port);
          cmp_field("host_length", want.host_length, res_if.host_length);
          cmp_field("host_byte", want.host_byte, res_if.host_byte);
        end
      end
      res_ready_q <= steady || ($urandom_range(99, 0) >= 13);
    end
  end

  task automatic push_word(input logic [7:0] b, input logic start);
    client_word_t w;
    w.data_byte = b;
    w.conn_start = start;
    client_words.push_back(w);
    words_queued++;
  endtask

  // Wait until every word is taken and every predicted result has come.
  task automatic drain();
    while (client_words.size() != 0 || in_valid_q || parse_results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_ipv6_cfg(input logic value);
    drain();
    repeat (8) @(posedge clk);
    cfg_valid_q <= 1'b1;
    cfg_ipv6_q  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_valid_q <= 1'b0;
    ipv6_off = value;
  endtask

  // fill: 0 all ones, 1 all zeros, else random
  function automatic logic [7:0] fill_byte(input int fill);
    if (fill == 0) return 8'hFF;
    if (fill == 1) return 8'h00;
    return 8'($urandom_range(255, 0));
  endfunction

  task automatic queue_session();
    logic [7:0] seq[$];
    logic [7:0] atyp;
    int         pick, n_meth, noauth_at, name_len, fill, cut;
    pick = $urandom_range(99, 0);
    if (pick < 10) begin
      // noise: random bytes, random connection starts
      repeat ($urandom_range(6, 1)) push_word(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
      return;
    end
    seq.push_back(SOCKS_VER);
    n_meth = ($urandom_range(39, 0) == 0) ? $urandom_range(255, 100) : $urandom_range(6, 1);
    noauth_at = ($urandom_range(9, 0) == 0) ? -1 : $urandom_range(n_meth - 1, 0);
    seq.push_back(8'(n_meth));
    for (int i = 0; i < n_meth; i++)
      seq.push_back((i == noauth_at) ? METH_NO_AUTH
                                     : 8'($urandom_range(255, (noauth_at < 0) ? 1 : 0)));
    seq.push_back(SOCKS_VER);
    seq.push_back(8'($urandom_range(CMD_LAST, CMD_FIRST)));
    seq.push_back(RSV_BYTE);
    case ($urandom_range(2, 0))
      0: atyp = ATYP_IPV4;
      1: atyp = ATYP_NAME;
      default: atyp = ATYP_IPV6;
    endcase
    seq.push_back(atyp);
    fill = $urandom_range(7, 0);
    if (atyp == ATYP_IPV4) begin
      repeat (IPV4_BYTES) seq.push_back(fill_byte(fill));
    end else if (atyp == ATYP_IPV6) begin
      repeat (IPV6_BYTES) seq.push_back(fill_byte(fill));
    end else begin
      name_len = ($urandom_range(29, 0) == 0) ? 255 : $urandom_range(10, 0);
      seq.push_back(8'(name_len));
      repeat (name_len) seq.push_back(8'($urandom_range(255, 0)));
    end
    repeat (2) seq.push_back(fill_byte(fill));
    if ($urandom_range(1, 0) == 1)
      repeat ($urandom_range(3, 1)) seq.push_back(8'($urandom_range(255, 0)));
    if (pick < 25) begin
      // broken session: corrupt one byte, mostly in the request header, or cut it short
      case ($urandom_range(2, 0))
        0: seq[$urandom_range(seq.size() - 1, 0)] = 8'($urandom_range(255, 0));
        1: seq[2 + n_meth + $urandom_range(3, 0)] = 8'($urandom_range(255, 0));
        default: begin
          cut = $urandom_range(seq.size() - 1, 1);
          while (seq.size() > cut) void'(seq.pop_back());
        end
      endcase
    end
    foreach (seq[i]) push_word(seq[i], i == 0);
  endtask

  task automatic run_sessions(input int unsigned until_count);
    while (words_queued < until_count) begin
      queue_session();
      if ($urandom_range(24, 0) == 0) drain();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_ipv6_cfg(1'b0);

    // bad greeting version, then a byte that must be dropped
    push_word(8'hFF, 1'b1);
    push_word(8'h00, 1'b0);
    // empty method list
    push_word(SOCKS_VER, 1'b1);
    push_word(8'h00, 1'b0);
    // no-auth method not offered
    push_word(SOCKS_VER, 1'b1);
    push_word(8'h01, 1'b0);
    push_word(8'hFF, 1'b0);
    // full IPv4 request with all-ones address and port, then trailing bytes
    push_word(SOCKS_VER, 1'b1);
    push_word(8'h01, 1'b0);
    push_word(METH_NO_AUTH, 1'b0);
    push_word(SOCKS_VER, 1'b0);
    push_word(CMD_LAST, 1'b0);
    push_word(RSV_BYTE, 1'b0);
    push_word(ATYP_IPV4, 1'b0);
    repeat (6) push_word(8'hFF, 1'b0);
    push_word(8'hAA, 1'b0);
    push_word(8'h00, 1'b0);
    drain();

    steady = 1'b1;
    run_sessions(words_queued + 300);
    drain();
    steady = 1'b0;
    run_sessions(words_queued + 400);

    write_ipv6_cfg(1'b1);
    run_sessions(words_queued + 400);

    write_ipv6_cfg(1'b0);
    run_sessions(words_queued + 250);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && parse_results_due.size() == 0) begin
      $display("tb_socks5_handshake_parser OK");
    end else begin
      $display("tb_socks5_handshake_parser NOT OK");
    end
    $finish;
  end

endmodule
